@@ hw/rtl/deppa_pkg.sv @@
// ----------------------------------------------------------------------------
// deppa_pkg
// Types and constants shared by the encoder period averager modules.
// ----------------------------------------------------------------------------
package deppa_pkg;

    localparam int TIMER_W   = 16;
    localparam int COUNT_W   = 32;
    localparam int LIMIT_W   = 18;
    localparam int PERIOD_W  = 16;
    localparam int OVF_W     = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [LIMIT_W-1:0]  SUM_LIMIT_RESET = 18'd2000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 16'hFFFF;
    localparam logic [OVF_W-1:0]    OVF_SAT         = 2'd2;

    // item kinds
    localparam logic MODE_POLL     = 1'b0;
    localparam logic MODE_OVERFLOW = 1'b1;

    // register byte addresses
    localparam logic [PADDR_W-1:0] REG_SUM_LIMIT = 3'd0;

    typedef struct packed {
        logic               mode;
        logic               left_stepped;
        logic               right_stepped;
        logic [TIMER_W-1:0] timer_now;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0]  left_position;
        logic [COUNT_W-1:0]  right_position;
        logic [PERIOD_W-1:0] left_period;
        logic [PERIOD_W-1:0] right_period;
        logic                history_cleared;
    } t_out_item;

    // per-lane command for the item being accepted
    typedef struct packed {
        logic               step;
        logic               clear;
        logic [TIMER_W-1:0] now;
    } t_lane_cmd;

    // pipeline movement shared by both lanes
    typedef struct packed {
        logic accept;
        logic adv1;
        logic adv2;
        logic adv3;
    } t_pipe_ctl;

endpackage

@@ hw/rtl/deppa_lane.sv @@
// ----------------------------------------------------------------------------
// deppa_lane
// One encoder channel: position, last stamp, period ring with running sum,
// then clamp and reciprocal divide into the averaged period.
// ----------------------------------------------------------------------------
module deppa_lane #(
    parameter int WINDOW_LEN = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  deppa_pkg::t_pipe_ctl          i_ctl,
    input  deppa_pkg::t_lane_cmd          i_cmd,
    input  logic [deppa_pkg::LIMIT_W-1:0] i_sum_limit,
    output logic [deppa_pkg::COUNT_W-1:0] o_position,
    output logic [deppa_pkg::PERIOD_W-1:0] o_period
);
    import deppa_pkg::*;

    localparam int IDX_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W   = TIMER_W + $clog2(WINDOW_LEN);
    localparam int CMP_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int SHIFT   = LIMIT_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = LIMIT_W + 1;
    localparam int PROD_W  = LIMIT_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(WINDOW_LEN - 1);

    // channel state
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TIMER_W-1:0] r_stamp, n_stamp;
    logic [TIMER_W-1:0] r_window [WINDOW_LEN];
    logic [TIMER_W-1:0] n_window [WINDOW_LEN];
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SUM_W-1:0]   r_sum, n_sum;

    // pipeline
    logic               r_s1_step;
    logic [COUNT_W-1:0] r_s1_count;
    logic [SUM_W-1:0]   r_s1_sum;
    logic               r_s2_step;
    logic [COUNT_W-1:0] r_s2_count;
    logic [LIMIT_W-1:0] r_s2_sum;
    logic [COUNT_W-1:0] r_position;
    logic [PERIOD_W-1:0] r_period;

    logic [TIMER_W-1:0] elapsed;
    logic [TIMER_W-1:0] old_entry;
    logic [LIMIT_W-1:0] clamped;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  quotient;

    always_comb begin
        // wrap case counts 65535 - last + now, which is now + ~last
        if (i_cmd.now >= r_stamp) begin
            elapsed = i_cmd.now - r_stamp;
        end else begin
            elapsed = i_cmd.now + ~r_stamp;
        end
        old_entry = r_window[r_idx];

        n_count  = r_count;
        n_stamp  = r_stamp;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_window = r_window;
        if (i_ctl.accept && i_cmd.clear) begin
            n_stamp = i_cmd.now;
            n_sum   = '0;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                n_window[k] = '0;
            end
        end else if (i_ctl.accept && i_cmd.step) begin
            n_count         = r_count + 1'b1;
            n_stamp         = i_cmd.now;
            n_window[r_idx] = elapsed;
            n_idx           = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            n_sum           = r_sum - SUM_W'(old_entry) + SUM_W'(elapsed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_stamp <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_window[k] <= '0;
            end
        end else begin
            r_count  <= n_count;
            r_stamp  <= n_stamp;
            r_idx    <= n_idx;
            r_sum    <= n_sum;
            r_window <= n_window;
        end
    end

    always_comb begin
        if (CMP_W'(r_s1_sum) > CMP_W'(i_sum_limit)) begin
            clamped = i_sum_limit;
        end else begin
            clamped = LIMIT_W'(r_s1_sum);
        end
        product  = PROD_W'(r_s2_sum) * PROD_W'(RECIP);
        quotient = product >> SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_step  <= 1'b0;
            r_s2_step  <= 1'b0;
            r_position <= '0;
            r_period   <= '0;
        end else begin
            if (i_ctl.adv1) begin
                r_s1_step <= i_ctl.accept && i_cmd.step;
            end
            if (i_ctl.adv2) begin
                r_s2_step <= r_s1_step;
            end
            if (i_ctl.adv3) begin
                r_position <= r_s2_count;
                if (r_s2_step) begin
                    if (quotient > PROD_W'(PERIOD_MAX)) begin
                        r_period <= PERIOD_MAX;
                    end else begin
                        r_period <= quotient[PERIOD_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_s1_count <= n_count;
            r_s1_sum   <= n_sum;
        end
        if (i_ctl.adv2) begin
            r_s2_count <= r_s1_count;
            r_s2_sum   <= clamped;
        end
    end

    assign o_position = r_position;
    assign o_period   = r_period;

endmodule

@@ hw/rtl/dual_encoder_period_averager.sv @@
// ----------------------------------------------------------------------------
// dual_encoder_period_averager
// Two-channel wheel encoder step counter and averaged period estimator.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// result per item via stages 1, 2 and the output. Each channel keeps a
// running window sum that is updated in the cycle an item is accepted, so
// the next item can follow at once; the clamp and the reciprocal multiply
// for the divide by WINDOW_LEN sit in the two following stages. Input and
// output are decoupled by the pipeline registers: items keep entering while
// a result waits, until all three stages are full. sum_limit is written
// through the APB port at byte address 0 and should change only while no
// item is in flight.
module dual_encoder_period_averager #(
    parameter int WINDOW_LEN = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  deppa_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output deppa_pkg::t_out_item          o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [deppa_pkg::PADDR_W-1:0] paddr,
    input  logic [deppa_pkg::PDATA_W-1:0] pwdata,
    output logic [deppa_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import deppa_pkg::*;

    logic [LIMIT_W-1:0] r_sum_limit;
    logic [OVF_W-1:0]   r_ovf, n_ovf;
    logic               r_v1, r_v2, r_out_valid;
    logic               r_s1_clr, r_s2_clr, r_out_clr;

    logic      rdy1, rdy2, rdy3;
    logic      clear_now;
    t_pipe_ctl ctl;
    t_lane_cmd left_cmd, right_cmd;

    // elastic pipeline: a stage moves when it is empty or its successor moves
    assign rdy3 = !r_out_valid || !i_out_stall;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign ctl.accept = i_in_valid && rdy1;
    assign ctl.adv1   = rdy1;
    assign ctl.adv2   = rdy2;
    assign ctl.adv3   = rdy3;

    assign clear_now = (i_in_data.mode == MODE_POLL) && (r_ovf >= OVF_SAT);

    assign left_cmd.clear  = clear_now;
    assign left_cmd.step   = (i_in_data.mode == MODE_POLL) && !clear_now
                             && i_in_data.left_stepped;
    assign left_cmd.now    = i_in_data.timer_now;
    assign right_cmd.clear = clear_now;
    assign right_cmd.step  = (i_in_data.mode == MODE_POLL) && !clear_now
                             && i_in_data.right_stepped;
    assign right_cmd.now   = i_in_data.timer_now;

    always_comb begin
        n_ovf = r_ovf;
        if (ctl.accept) begin
            if (i_in_data.mode == MODE_OVERFLOW) begin
                if (r_ovf < OVF_SAT) begin
                    n_ovf = r_ovf + 1'b1;
                end
            end else begin
                n_ovf = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_limit <= SUM_LIMIT_RESET;
            r_ovf       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && (paddr == REG_SUM_LIMIT)) begin
                r_sum_limit <= pwdata[LIMIT_W-1:0];
            end
            r_ovf <= n_ovf;
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_out_valid <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_clr <= clear_now;
        end
        if (rdy2) begin
            r_s2_clr <= r_s1_clr;
        end
        if (rdy3) begin
            r_out_clr <= r_s2_clr;
        end
    end

    deppa_lane #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_left_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cmd       (left_cmd),
        .i_sum_limit (r_sum_limit),
        .o_position  (o_out_data.left_position),
        .o_period    (o_out_data.left_period)
    );

    deppa_lane #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_right_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cmd       (right_cmd),
        .i_sum_limit (r_sum_limit),
        .o_position  (o_out_data.right_position),
        .o_period    (o_out_data.right_period)
    );

    assign o_out_data.history_cleared = r_out_clr;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = !rdy1;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SUM_LIMIT) ? PDATA_W'(r_sum_limit) : '0;

endmodule

@@ hw/rtl/deppa_checker.sv @@
// ----------------------------------------------------------------------------
// deppa_checker
// Port-level checks on the encoder period averager, bound to the top level.
// ----------------------------------------------------------------------------
module deppa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  deppa_pkg::t_in_item           i_in_data,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  deppa_pkg::t_out_item          o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [deppa_pkg::PADDR_W-1:0] paddr,
    input  logic [deppa_pkg::PDATA_W-1:0] pwdata,
    input  logic [deppa_pkg::PDATA_W-1:0] prdata,
    input  logic                          pready
);
    import deppa_pkg::*;

    logic               out_fire;
    logic               r_have;
    logic [COUNT_W-1:0] r_prev_left, r_prev_right;
    logic [COUNT_W-1:0] left_delta, right_delta;

    assign out_fire    = o_out_valid && !i_out_stall;
    assign left_delta  = o_out_data.left_position - r_prev_left;
    assign right_delta = o_out_data.right_position - r_prev_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (out_fire) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_prev_left  <= o_out_data.left_position;
            r_prev_right <= o_out_data.right_position;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    a_position_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_have |->
            (left_delta == '0 || left_delta == COUNT_W'(1)) &&
            (right_delta == '0 || right_delta == COUNT_W'(1)))
        else $error("position moved by more than one step");

    a_clear_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_have && o_out_data.history_cleared |->
            left_delta == '0 && right_delta == '0)
        else $error("history clear changed a position");

endmodule

bind dual_encoder_period_averager deppa_checker u_deppa_checker (.*);

@@ tb/sv/dual_encoder_period_averager_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_encoder_period_averager_tb
// Self-checking bench for the two-channel encoder period averager.
// ----------------------------------------------------------------------------
// Drives poll and overflow items through the valid/stall input and keeps its
// own copy of both wheel channels to predict every result: step counts, ring
// of elapsed ticks, clamped window sum and averaged period. Results are
// compared field by field in arrival order. Covers directed corner items,
// the sum limit at both ends through the APB port, random traffic under
// changing idle patterns and a long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module dual_encoder_period_averager_tb;
    import deppa_pkg::*;

    localparam int WIN_LEN = 3;
    localparam int QUIET_LIMIT = 2000;
    localparam int unsigned LIMIT_TOP = 196605;
    // wrap adds 65535, one short of a full turn of the timer
    localparam int unsigned TICK_WRAP = 65535;

    typedef struct packed {
        logic [COUNT_W-1:0]                steps;
        logic [TIMER_W-1:0]                stamp;
        logic [WIN_LEN-1:0][TIMER_W-1:0]   ring;
        logic [1:0]                        slot;
        logic [PERIOD_W-1:0]               avg;
    } t_wheel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    t_wheel             left_wheel = '0;
    t_wheel             right_wheel = '0;
    logic [OVF_W-1:0]   ovf_seen = '0;
    logic [LIMIT_W-1:0] limit_model = SUM_LIMIT_RESET;
    logic [TIMER_W-1:0] run_timer = '0;
    t_out_item          expected_readings[$];

    int fail_count = 0;
    int quiet_cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;

    dual_encoder_period_averager #(
        .WINDOW_LEN (WIN_LEN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // channel prediction
    // ------------------------------------------------------------------
    function automatic t_wheel wheel_advance(t_wheel w, logic [TIMER_W-1:0] now);
        int unsigned ticks;
        int unsigned total;
        int unsigned quot;
        int k;
        w.steps = w.steps + 1'b1;
        if (now >= w.stamp) begin
            ticks = now - w.stamp;
        end else begin
            ticks = TICK_WRAP - w.stamp + now;
        end
        w.stamp = now;
        if (w.slot >= WIN_LEN) begin
            w.slot = '0;
        end
        w.ring[w.slot] = ticks[TIMER_W-1:0];
        w.slot = w.slot + 1'b1;
        total = 0;
        for (k = 0; k < WIN_LEN; k++) begin
            total += w.ring[k];
        end
        if (total > limit_model) begin
            total = limit_model;
        end
        quot = total / WIN_LEN;
        if (quot > PERIOD_MAX) begin
            quot = PERIOD_MAX;
        end
        w.avg = quot[PERIOD_W-1:0];
        return w;
    endfunction

    function automatic t_out_item predict_reading(t_in_item it);
        t_out_item r;
        r.history_cleared = 1'b0;
        if (it.mode == MODE_OVERFLOW) begin
            if (ovf_seen < OVF_SAT) begin
                ovf_seen = ovf_seen + 1'b1;
            end
        end else if (ovf_seen >= OVF_SAT) begin
            // stale history after repeated overflow: restart both rings
            ovf_seen = '0;
            left_wheel.ring = '0;
            right_wheel.ring = '0;
            left_wheel.stamp = it.timer_now;
            right_wheel.stamp = it.timer_now;
            r.history_cleared = 1'b1;
        end else begin
            ovf_seen = '0;
            if (it.left_stepped) begin
                left_wheel = wheel_advance(left_wheel, it.timer_now);
            end
            if (it.right_stepped) begin
                right_wheel = wheel_advance(right_wheel, it.timer_now);
            end
        end
        r.left_position = left_wheel.steps;
        r.right_position = right_wheel.steps;
        r.left_period = left_wheel.avg;
        r.right_period = right_wheel.avg;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // item helpers
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(logic mode, logic lstep, logic rstep,
                                           logic [TIMER_W-1:0] now);
        t_in_item it;
        it.mode = mode;
        it.left_stepped = lstep;
        it.right_stepped = rstep;
        it.timer_now = now;
        return it;
    endfunction

    function automatic t_in_item next_poll();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            run_timer = run_timer + TIMER_W'($urandom_range(900));
        end else if (pick < 92) begin
            run_timer = run_timer + TIMER_W'($urandom_range(30000));
        end else begin
            run_timer = TIMER_W'($urandom);
        end
        return make_item(MODE_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         run_timer);
    endfunction

    function automatic t_in_item overflow_noise();
        t_in_item it;
        it.mode = MODE_OVERFLOW;
        it.left_stepped = 1'($urandom_range(1));
        it.right_stepped = 1'($urandom_range(1));
        it.timer_now = TIMER_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_readings.push_back(predict_reading(it));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= REG_SUM_LIMIT;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sum_limit(input int unsigned value);
        logic [PDATA_W-1:0] rb;
        wait_drained();
        repeat (4) @(posedge i_clk);
        apb_transfer(1'b1, value, rb);
        limit_model = value[LIMIT_W-1:0];
        @(posedge i_clk);
        apb_transfer(1'b0, '0, rb);
        if (rb[LIMIT_W-1:0] !== limit_model) begin
            $error("sum_limit readback: expected %0d, actual %0d", limit_model,
                   rb[LIMIT_W-1:0]);
            fail_count++;
        end
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [PDATA_W-1:0] rb;
        apb_transfer(1'b0, '0, rb);
        if (rb[LIMIT_W-1:0] !== SUM_LIMIT_RESET) begin
            $error("sum_limit reset: expected %0d, actual %0d", SUM_LIMIT_RESET,
                   rb[LIMIT_W-1:0]);
            fail_count++;
        end
        @(posedge i_clk);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_item(make_item(MODE_POLL, 1'b0, 1'b0, 16'd0));
        send_item(make_item(MODE_POLL, 1'b1, 1'b0, 16'd100));
        send_item(make_item(MODE_POLL, 1'b0, 1'b1, 16'd300));
        // left sees 200 ticks, right sees equal stamps
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'd300));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'd300));
        // huge gap clamps the window sum
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'hFFFF));
        // timer wrap
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'd5));
        send_item(make_item(MODE_OVERFLOW, 1'b1, 1'b1, 16'hFFFF));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'd20));
        // overflow count saturates, then a clearing poll ignores the flags
        send_item(make_item(MODE_OVERFLOW, 1'b0, 1'b0, 16'd0));
        send_item(make_item(MODE_OVERFLOW, 1'b1, 1'b0, 16'h5555));
        send_item(make_item(MODE_OVERFLOW, 1'b0, 1'b1, 16'hAAAA));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'hFFFF));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'h0010));
        send_item(make_item(MODE_POLL, 1'b1, 1'b0, 16'h8000));
        send_item(make_item(MODE_POLL, 1'b0, 1'b1, 16'h7FFF));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'h8100));
        send_item(make_item(MODE_OVERFLOW, 1'b0, 1'b0, 16'd0));
        send_item(make_item(MODE_OVERFLOW, 1'b0, 1'b0, 16'd0));
        send_item(make_item(MODE_POLL, 1'b0, 1'b0, 16'h1234));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'h1300));
        send_item(make_item(MODE_POLL, 1'b1, 1'b1, 16'h1400));
        run_timer = 16'h1400;
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        int k;
        tx_idle_pct = 20;
        rx_stall_pct = 20;
        set_sum_limit(0);
        for (k = 0; k < 20; k++) begin
            send_item(next_poll());
        end
        set_sum_limit(LIMIT_TOP);
        for (k = 0; k < 30; k++) begin
            send_item(next_poll());
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct,
                                       input int unsigned limit);
        int sent;
        int pick;
        int runs;
        int k;
        set_sum_limit(limit);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // overflow run followed by the poll that clears history
                runs = $urandom_range(2, 3);
                for (k = 0; k < runs; k++) begin
                    send_item(overflow_noise());
                end
                send_item(next_poll());
                sent += runs + 1;
            end else if (pick < 14) begin
                send_item(overflow_noise());
                send_item(next_poll());
                sent += 2;
            end else begin
                send_item(next_poll());
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        int k;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 60;
        for (k = 0; k < 25; k++) begin
            send_item(next_poll());
        end
        // sender waits for every result before going on
        wait_drained();
        for (k = 0; k < 15; k++) begin
            send_item(next_poll());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // output side: stall generation and result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                $error("result with no item pending: %h", o_out_data);
                fail_count++;
            end else begin
                want = expected_readings.pop_front();
                check_field("left_position", want.left_position, o_out_data.left_position);
                check_field("right_position", want.right_position,
                            o_out_data.right_position);
                check_field("left_period", COUNT_W'(want.left_period),
                            COUNT_W'(o_out_data.left_period));
                check_field("right_period", COUNT_W'(want.right_period),
                            COUNT_W'(o_out_data.right_period));
                check_field("history_cleared", COUNT_W'(want.history_cleared),
                            COUNT_W'(o_out_data.history_cleared));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_extremes();
        test_random_traffic(380, 12, 59, 1500);
        test_random_traffic(380, 59, 12, $urandom_range(LIMIT_TOP));
        test_output_holdoff();
        test_random_traffic(280, 0, 0, LIMIT_TOP);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
